@@ src/ll1pp_pkg.sv @@
`default_nettype none

package ll1pp_pkg;

  localparam int SYM_W    = 7;
  localparam int MAX_SYMS = 8;
  localparam int PROD_W   = SYM_W * MAX_SYMS;
  localparam int LEN_W    = 4;
  localparam int TBL_AW   = 2 * SYM_W;

  localparam int STACK_DEPTH_D    = 64;
  localparam int MAX_PROD_LEN_D   = 8;
  localparam int MAX_EXPANSIONS_D = 16;

  localparam logic [SYM_W-1:0] END_MARK    = 7'd35;
  localparam logic [SYM_W-1:0] EPS_MARK    = 7'd36;
  localparam logic [SYM_W-1:0] NEWLINE     = 7'd10;
  localparam logic [SYM_W-1:0] START_RESET = 7'd83;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_TOKEN   = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    K_MATCH  = 2'd0,
    K_EXPAND = 2'd1,
    K_ACCEPT = 2'd2,
    K_ERROR  = 2'd3
  } kind_t;

  typedef struct packed {
    logic              valid;
    logic [LEN_W-1:0]  len;
    logic [PROD_W-1:0] prod;
  } tbl_entry_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    tbl_entry_t        wdata;
    logic              re;
    logic [TBL_AW-1:0] raddr;
  } tbl_req_t;

  typedef struct packed {
    kind_t             kind;
    logic [SYM_W-1:0]  top;
    logic [PROD_W-1:0] prod;
    logic [LEN_W-1:0]  len;
    logic              last;
  } res_t;

  function automatic logic [PROD_W-1:0] prod_mask(input logic [LEN_W-1:0] len);
    logic [PROD_W-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_SYMS; i++) begin
      if (LEN_W'(i) < len) begin
        m[i*SYM_W +: SYM_W] = '1;
      end
    end
    return m;
  endfunction

  function automatic logic [SYM_W-1:0] sym_at(input logic [PROD_W-1:0] prod,
                                              input logic [2:0] idx);
    return prod[idx*SYM_W +: SYM_W];
  endfunction

endpackage

`default_nettype wire

@@ src/ll1pp_if.sv @@
`default_nettype none

interface ll1pp_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          op;
  logic [ll1pp_pkg::SYM_W-1:0]         table_row;
  logic [ll1pp_pkg::SYM_W-1:0]         table_col;
  logic [ll1pp_pkg::PROD_W-1:0]        production;
  logic [ll1pp_pkg::LEN_W-1:0]         production_length;
  logic [ll1pp_pkg::SYM_W-1:0]         token;

  modport source (output valid, op, table_row, table_col, production,
                  production_length, token, input ready);
  modport sink (input valid, op, table_row, table_col, production,
                production_length, token, output ready);
endinterface

interface ll1pp_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic [ll1pp_pkg::SYM_W-1:0]         top_symbol;
  logic [ll1pp_pkg::PROD_W-1:0]        applied_production;
  logic [ll1pp_pkg::LEN_W-1:0]         applied_length;
  logic                                last;

  modport source (output valid, kind, top_symbol, applied_production,
                  applied_length, last, input ready);
  modport sink (input valid, kind, top_symbol, applied_production,
                applied_length, last, output ready);
endinterface

`default_nettype wire

@@ src/ll1pp_table_ram.sv @@
`default_nettype none

module ll1pp_table_ram (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ll1pp_pkg::tbl_req_t     req,
  output ll1pp_pkg::tbl_entry_t   rdata,
  output logic                    busy
);
  import ll1pp_pkg::*;

  localparam int TBL_DEPTH = 1 << TBL_AW;

  tbl_entry_t        mem [TBL_DEPTH];
  tbl_entry_t        rdata_r;
  logic [TBL_AW-1:0] clr_addr_r;
  logic [TBL_AW-1:0] clr_addr_nxt;
  logic              busy_r;
  logic              busy_nxt;

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    busy_nxt     = busy_r;
    if (busy_r) begin
      clr_addr_nxt = clr_addr_r + TBL_AW'(1);
      if (clr_addr_r == {TBL_AW{1'b1}}) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

`default_nettype wire

@@ src/ll1pp_stack_ram.sv @@
`default_nettype none

module ll1pp_stack_ram #(
  parameter int DEPTH = ll1pp_pkg::STACK_DEPTH_D,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [ll1pp_pkg::SYM_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [ll1pp_pkg::SYM_W-1:0] rdata
);
  import ll1pp_pkg::*;

  logic [SYM_W-1:0] mem [DEPTH];
  logic [SYM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ src/ll1_predictive_parse_driver_core.sv @@
`default_nettype none

// Channel   Dir  Word
// in_ch     in   op, table_row, table_col, production, production_length, token
// out_ch    out  kind, top_symbol, applied_production, applied_length, last
// cfg_*     in   start_symbol, written whenever cfg_we is high
//
// Neither a table write nor a restart gives a result.
// A token reads the stack top in S_RDTOP and is first decided in S_LOOK. An expansion
// reads the table, gives its result in S_EXP and pushes the production one symbol at
// a time in S_PUSH over the single stack write port; both memories have registered reads.
// After reset all 16384 table entries are cleared before the first word is taken.
// A full output register stalls the sequencer where it would issue the next result.

module ll1_predictive_parse_driver_core #(
  parameter int STACK_DEPTH    = ll1pp_pkg::STACK_DEPTH_D,
  parameter int MAX_PROD_LEN   = ll1pp_pkg::MAX_PROD_LEN_D,
  parameter int MAX_EXPANSIONS = ll1pp_pkg::MAX_EXPANSIONS_D
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ll1pp_in_if.sink                    in_ch,
  ll1pp_out_if.source                 out_ch,
  input  logic                        cfg_we,
  input  logic [ll1pp_pkg::SYM_W-1:0] cfg_wdata
);
  import ll1pp_pkg::*;

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int SPW  = $clog2(STACK_DEPTH + 1);
  localparam int EXPW = $clog2(MAX_EXPANSIONS + 1);
  localparam int OVW  = ((SPW > LEN_W) ? SPW : LEN_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESTART,
    S_RDTOP,
    S_LOOK,
    S_EXP,
    S_PUSH
  } state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACTIVE,
    ST_ACCEPTED,
    ST_ERROR
  } status_t;

  state_t            state_r, state_nxt;
  status_t           status_r, status_nxt;
  logic [SPW-1:0]    sp_r, sp_nxt;
  logic [SYM_W-1:0]  start_r, start_nxt;
  logic [SYM_W-1:0]  tok_r, tok_nxt;
  logic [SYM_W-1:0]  top_r, top_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [EXPW-1:0]   exp_cnt_r, exp_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r, out_nxt;

  tbl_req_t          tbl_req;
  tbl_entry_t        tbl_rdata;
  logic              tbl_busy;

  logic              stk_we;
  logic [AW-1:0]     stk_waddr;
  logic [SYM_W-1:0]  stk_wdata;
  logic              stk_re;
  logic [AW-1:0]     stk_raddr;
  logic [SYM_W-1:0]  stk_rdata;

  logic              accept;
  logic              out_free;
  logic [SPW-1:0]    sp_dec;
  logic [SYM_W-1:0]  top_now;
  logic [LEN_W-1:0]  push_cnt;
  logic [LEN_W-1:0]  wr_len;
  logic [SYM_W-1:0]  push_sym;
  logic [OVW-1:0]    sp_after;

  ll1pp_table_ram u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rdata (tbl_rdata),
    .busy  (tbl_busy)
  );

  ll1pp_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  function automatic res_t make_res(input kind_t k, input logic [SYM_W-1:0] t,
                                    input logic [PROD_W-1:0] p,
                                    input logic [LEN_W-1:0] l, input logic la);
    res_t r;
    r.kind = k;
    r.top  = t;
    r.prod = p;
    r.len  = l;
    r.last = la;
    return r;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE) && !tbl_busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign sp_dec      = sp_r - SPW'(1);
  assign top_now     = (sp_r == '0) ? '0 : stk_rdata;
  assign wr_len      = (in_ch.production_length > LEN_W'(MAX_PROD_LEN)) ?
                       LEN_W'(MAX_PROD_LEN) : in_ch.production_length;
  assign push_sym    = sym_at(prod_r, 3'(idx_r - LEN_W'(1)));
  assign sp_after    = OVW'(sp_r) - OVW'(1) + OVW'(push_cnt);

  always_comb begin
    push_cnt = '0;
    for (int i = 0; i < MAX_SYMS; i++) begin
      if ((LEN_W'(i) < tbl_rdata.len) && (sym_at(tbl_rdata.prod, 3'(i)) != EPS_MARK)) begin
        push_cnt = push_cnt + LEN_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    sp_nxt        = sp_r;
    start_nxt     = cfg_we ? cfg_wdata : start_r;
    tok_nxt       = tok_r;
    top_nxt       = top_r;
    prod_nxt      = prod_r;
    idx_nxt       = idx_r;
    exp_cnt_nxt   = exp_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    tbl_req       = '0;
    stk_we        = 1'b0;
    stk_waddr     = '0;
    stk_wdata     = '0;
    stk_re        = 1'b0;
    stk_raddr     = sp_dec[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(in_ch.op))
            OP_WRITE: begin
              tbl_req.we          = 1'b1;
              tbl_req.waddr       = {in_ch.table_row, in_ch.table_col};
              tbl_req.wdata.valid = 1'b1;
              tbl_req.wdata.len   = wr_len;
              tbl_req.wdata.prod  = in_ch.production &
                                    prod_mask(LEN_W'(MAX_PROD_LEN));
            end
            OP_RESTART: begin
              stk_we     = 1'b1;
              stk_waddr  = AW'(0);
              stk_wdata  = END_MARK;
              sp_nxt     = SPW'(2);
              status_nxt = ST_ACTIVE;
              tok_nxt    = start_r;
              state_nxt  = S_RESTART;
            end
            OP_TOKEN: begin
              tok_nxt     = (in_ch.token == NEWLINE) ? END_MARK : in_ch.token;
              exp_cnt_nxt = '0;
              state_nxt   = S_RDTOP;
            end
            default: begin
            end
          endcase
        end
      end
      S_RESTART: begin
        stk_we    = 1'b1;
        stk_waddr = AW'(1);
        stk_wdata = tok_r;
        state_nxt = S_IDLE;
      end
      S_RDTOP: begin
        stk_re    = 1'b1;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        if (out_free) begin
          if (status_r != ST_ACTIVE) begin
            out_valid_nxt = 1'b1;
            out_nxt       = make_res(K_ERROR, top_now, '0, '0, 1'b1);
            state_nxt     = S_IDLE;
          end else if (sp_r == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = make_res(K_ERROR, '0, '0, '0, 1'b1);
            status_nxt    = ST_ERROR;
            state_nxt     = S_IDLE;
          end else if ((top_now == END_MARK) && (tok_r == END_MARK)) begin
            out_valid_nxt = 1'b1;
            out_nxt       = make_res(K_ACCEPT, top_now, '0, '0, 1'b1);
            status_nxt    = ST_ACCEPTED;
            state_nxt     = S_IDLE;
          end else if (top_now == tok_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = make_res(K_MATCH, top_now, '0, '0, 1'b1);
            sp_nxt        = sp_dec;
            state_nxt     = S_IDLE;
          end else begin
            tbl_req.re    = 1'b1;
            tbl_req.raddr = {top_now, tok_r};
            top_nxt       = top_now;
            state_nxt     = S_EXP;
          end
        end
      end
      S_EXP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (!tbl_rdata.valid || (exp_cnt_r >= EXPW'(MAX_EXPANSIONS)) ||
              (sp_after > OVW'(STACK_DEPTH))) begin
            out_nxt    = make_res(K_ERROR, top_r, '0, '0, 1'b1);
            status_nxt = ST_ERROR;
            state_nxt  = S_IDLE;
          end else begin
            out_nxt     = make_res(K_EXPAND, top_r,
                                   tbl_rdata.prod & prod_mask(tbl_rdata.len),
                                   tbl_rdata.len, 1'b0);
            sp_nxt      = sp_dec;
            prod_nxt    = tbl_rdata.prod;
            idx_nxt     = tbl_rdata.len;
            exp_cnt_nxt = exp_cnt_r + EXPW'(1);
            state_nxt   = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (idx_r == '0) begin
          state_nxt = S_RDTOP;
        end else begin
          if (push_sym != EPS_MARK) begin
            stk_we    = 1'b1;
            stk_waddr = sp_r[AW-1:0];
            stk_wdata = push_sym;
            sp_nxt    = sp_r + SPW'(1);
          end
          idx_nxt = idx_r - LEN_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_IDLE;
      sp_r        <= '0;
      start_r     <= START_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      sp_r        <= sp_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tok_r     <= tok_nxt;
    top_r     <= top_nxt;
    prod_r    <= prod_nxt;
    idx_r     <= idx_nxt;
    exp_cnt_r <= exp_cnt_nxt;
    out_r     <= out_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.kind               = out_r.kind;
  assign out_ch.top_symbol         = out_r.top;
  assign out_ch.applied_production = out_r.prod;
  assign out_ch.applied_length     = out_r.len;
  assign out_ch.last               = out_r.last;

endmodule

`default_nettype wire

@@ src/ll1pp_checker.sv @@
`default_nettype none

module ll1pp_checker (
  input  logic         clk,
  input  logic         rst_n,
  ll1pp_in_if.sink     in_ch,
  ll1pp_out_if.source  out_ch
);
  import ll1pp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      out_ch.valid && $stable(out_ch.kind) && $stable(out_ch.top_symbol) &&
      $stable(out_ch.applied_production) && $stable(out_ch.applied_length) &&
      $stable(out_ch.last))
    else $error("Result word changed or dropped while stalled.");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.kind == K_EXPAND) != out_ch.last))
    else $error("Only an expand word may leave last low.");

  a_no_prod: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.kind != K_EXPAND) |->
      (out_ch.applied_production == '0) && (out_ch.applied_length == '0))
    else $error("A non-expand word carries a production.");

  a_clear_pass: assert property (@(posedge clk)
    !rst_n |=> !in_ch.ready)
    else $error("Input taken while the table is being cleared.");

endmodule

bind ll1_predictive_parse_driver_core ll1pp_checker u_ll1pp_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire

@@ dv/ll1pp_parse_checker.sv @@
module ll1pp_parse_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  ll1pp_in_if                         in_ch,
  ll1pp_out_if                        out_ch,
  input  logic                        cfg_we,
  input  logic [ll1pp_pkg::SYM_W-1:0] cfg_wdata,
  output logic [31:0]                 results_owed,
  output logic [31:0]                 mismatch_count
);
  import ll1pp_pkg::*;

  localparam int TBL_SIZE  = 1 << TBL_AW;
  localparam int SHOWN_MAX = 10;

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_ACTIVE,
    PARSE_ACCEPTED,
    PARSE_ERROR
  } parse_state_t;

  logic [SYM_W-1:0]  start_sym;
  logic [SYM_W-1:0]  stack_mem [STACK_DEPTH_D];
  int unsigned       depth;
  logic              rule_valid [TBL_SIZE];
  logic [LEN_W-1:0]  rule_len [TBL_SIZE];
  logic [PROD_W-1:0] rule_rhs [TBL_SIZE];
  parse_state_t      pstate;
  res_t              owed_q[$];
  int                errors;
  int                results_seen;

  assign mismatch_count = errors;

  function automatic logic [PROD_W-1:0] keep_syms(input logic [PROD_W-1:0] rhs,
                                                  input logic [LEN_W-1:0] n);
    if (n >= MAX_SYMS) return rhs;
    return rhs & ((PROD_W'(1) << (n * SYM_W)) - PROD_W'(1));
  endfunction

  task automatic owe(input kind_t k, input logic [SYM_W-1:0] top_sym,
                     input logic [PROD_W-1:0] rhs, input logic [LEN_W-1:0] n,
                     input logic fin);
    res_t r;
    r.kind = k;
    r.top  = top_sym;
    r.prod = rhs;
    r.len  = n;
    r.last = fin;
    owed_q = {owed_q, r};
  endtask

  task automatic parse_token(input logic [SYM_W-1:0] tok_in);
    logic [SYM_W-1:0]  tok;
    logic [SYM_W-1:0]  top_now;
    logic [SYM_W-1:0]  s;
    logic [TBL_AW-1:0] addr;
    logic [PROD_W-1:0] rhs;
    int unsigned       expansions;
    int unsigned       cnt;
    bit                done;
    tok = (tok_in == NEWLINE) ? END_MARK : tok_in;
    if (pstate != PARSE_ACTIVE) begin
      owe(K_ERROR, (depth == 0) ? '0 : stack_mem[depth-1], '0, '0, 1'b1);
      return;
    end
    expansions = 0;
    done = 1'b0;
    while (!done) begin
      if (depth == 0) begin
        pstate = PARSE_ERROR;
        owe(K_ERROR, '0, '0, '0, 1'b1);
        done = 1'b1;
      end else begin
        top_now = stack_mem[depth-1];
        addr = {top_now, tok};
        rhs = rule_rhs[addr];
        if (top_now == END_MARK && tok == END_MARK) begin
          pstate = PARSE_ACCEPTED;
          owe(K_ACCEPT, top_now, '0, '0, 1'b1);
          done = 1'b1;
        end else if (top_now == tok) begin
          depth--;
          owe(K_MATCH, top_now, '0, '0, 1'b1);
          done = 1'b1;
        end else if (!rule_valid[addr] || expansions >= MAX_EXPANSIONS_D) begin
          pstate = PARSE_ERROR;
          owe(K_ERROR, top_now, '0, '0, 1'b1);
          done = 1'b1;
        end else begin
          cnt = 0;
          for (int i = 0; i < rule_len[addr]; i++) begin
            if (rhs[i*SYM_W +: SYM_W] != EPS_MARK) cnt++;
          end
          if (depth - 1 + cnt > STACK_DEPTH_D) begin
            pstate = PARSE_ERROR;
            owe(K_ERROR, top_now, '0, '0, 1'b1);
            done = 1'b1;
          end else begin
            depth--;
            for (int i = int'(rule_len[addr]); i > 0; i--) begin
              s = rhs[(i-1)*SYM_W +: SYM_W];
              if (s != EPS_MARK) begin
                stack_mem[depth] = s;
                depth++;
              end
            end
            owe(K_EXPAND, top_now, keep_syms(rhs, rule_len[addr]), rule_len[addr], 1'b0);
            expansions++;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      start_sym = START_RESET;
      depth = 0;
      pstate = PARSE_IDLE;
      for (int i = 0; i < TBL_SIZE; i++) rule_valid[i] = 1'b0;
      owed_q.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind = kind_t'(out_ch.kind);
        got.top  = out_ch.top_symbol;
        got.prod = out_ch.applied_production;
        got.len  = out_ch.applied_length;
        got.last = out_ch.last;
        if (owed_q.size() == 0) begin
          errors++;
          if (errors <= SHOWN_MAX) begin
            $display({"result %0d arrived with nothing owed: ",
                      "kind %0d top %h rhs %h len %0d last %0d"},
                     results_seen, got.kind, got.top, got.prod, got.len, got.last);
          end
        end else begin
          want = owed_q.pop_front();
          if (got.kind !== want.kind || got.top !== want.top || got.prod !== want.prod ||
              got.len !== want.len || got.last !== want.last) begin
            errors++;
            if (errors <= SHOWN_MAX) begin
              $display({"result %0d mismatch: expected ",
                        "kind %0d top %h rhs %h len %0d last %0d"},
                       results_seen, want.kind, want.top, want.prod, want.len, want.last);
              $display({"result %0d mismatch: got      ",
                        "kind %0d top %h rhs %h len %0d last %0d"},
                       results_seen, got.kind, got.top, got.prod, got.len, got.last);
            end
          end
        end
        results_seen++;
      end
      if (cfg_we) start_sym = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.op)
          OP_WRITE: begin
            rule_valid[{in_ch.table_row, in_ch.table_col}] = 1'b1;
            rule_len[{in_ch.table_row, in_ch.table_col}] =
              (in_ch.production_length > MAX_PROD_LEN_D) ? LEN_W'(MAX_PROD_LEN_D)
                                                         : in_ch.production_length;
            rule_rhs[{in_ch.table_row, in_ch.table_col}] = in_ch.production;
          end
          OP_TOKEN: begin
            parse_token(in_ch.token);
          end
          OP_RESTART: begin
            stack_mem[0] = END_MARK;
            stack_mem[1] = start_sym;
            depth = 2;
            pstate = PARSE_ACTIVE;
          end
          default: begin
          end
        endcase
      end
    end
    results_owed <= owed_q.size();
  end

endmodule

@@ dv/ll1_predictive_parse_driver_core_tb.sv @@
module ll1_predictive_parse_driver_core_tb;
  import ll1pp_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int PHASE_WORDS    = 55;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [SYM_W-1:0] NT_S    = 7'h53;
  localparam logic [SYM_W-1:0] NT_E    = 7'h45;
  localparam logic [SYM_W-1:0] NT_R    = 7'h52;
  localparam logic [SYM_W-1:0] NT_T    = 7'h54;
  localparam logic [SYM_W-1:0] NT_Y    = 7'h59;
  localparam logic [SYM_W-1:0] NT_F    = 7'h46;
  localparam logic [SYM_W-1:0] T_ID    = 7'h69;
  localparam logic [SYM_W-1:0] T_PLUS  = 7'h2B;
  localparam logic [SYM_W-1:0] T_STAR  = 7'h2A;
  localparam logic [SYM_W-1:0] T_OPEN  = 7'h28;
  localparam logic [SYM_W-1:0] T_CLOSE = 7'h29;
  localparam logic [SYM_W-1:0] T_LOOP  = 7'h79;
  localparam logic [SYM_W-1:0] T_GROW  = 7'h78;
  localparam logic [SYM_W-1:0] T_DROP  = 7'h77;
  localparam logic [SYM_W-1:0] T_WIDE  = 7'h76;
  localparam logic [SYM_W-1:0] T_MASK  = 7'h75;
  localparam logic [SYM_W-1:0] SYM_LOW  = 7'd0;
  localparam logic [SYM_W-1:0] SYM_HIGH = 7'd127;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [SYM_W-1:0] cfg_wdata;
  wire  [31:0]      results_owed;
  wire  [31:0]      mismatch_count;

  int               burst_left;
  int               words_sent;
  int               ready_hold;
  int               quiet_cycles;
  logic [SYM_W-1:0] sentence_q[$];

  ll1pp_in_if  in_ch ();
  ll1pp_out_if out_ch ();

  ll1_predictive_parse_driver_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ll1pp_parse_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .results_owed   (results_owed),
    .mismatch_count (mismatch_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    int r;
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        out_ch.ready <= 1'b1;
        ready_hold = $urandom_range(30, 80);
      end else if (r < 8) begin
        out_ch.ready <= 1'($urandom_range(0, 1));
        ready_hold = $urandom_range(0, 3);
      end else begin
        out_ch.ready <= 1'b0;
        ready_hold = $urandom_range(15, 40);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(20, 50);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [SYM_W-1:0] rand_sym();
    return SYM_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [PROD_W-1:0] rand_rhs();
    return PROD_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [PROD_W-1:0] rhs_of(input string text);
    logic [PROD_W-1:0] p;
    byte               c;
    p = '0;
    for (int i = 0; i < text.len() && i < MAX_SYMS; i++) begin
      c = text[i];
      p[i*SYM_W +: SYM_W] = c[SYM_W-1:0];
    end
    return p;
  endfunction

  function automatic logic [SYM_W-1:0] any_terminal();
    case ($urandom_range(0, 5))
      0: return T_ID;
      1: return T_PLUS;
      2: return T_STAR;
      3: return T_OPEN;
      4: return T_CLOSE;
      default: return END_MARK;
    endcase
  endfunction

  function automatic void add_factor(input int lvl);
    if (lvl < 3 && $urandom_range(0, 3) == 0) begin
      sentence_q = {sentence_q, T_OPEN};
      add_expr(lvl + 1);
      sentence_q = {sentence_q, T_CLOSE};
    end else begin
      sentence_q = {sentence_q, T_ID};
    end
  endfunction

  function automatic void add_term(input int lvl);
    add_factor(lvl);
    while ($urandom_range(0, 9) < 3) begin
      sentence_q = {sentence_q, T_STAR};
      add_factor(lvl);
    end
  endfunction

  function automatic void add_expr(input int lvl);
    add_term(lvl);
    while ($urandom_range(0, 9) < 3) begin
      sentence_q = {sentence_q, T_PLUS};
      add_term(lvl);
    end
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [SYM_W-1:0] row,
                           input logic [SYM_W-1:0] col, input logic [PROD_W-1:0] rhs,
                           input logic [LEN_W-1:0] n, input logic [SYM_W-1:0] tok);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.op                <= op;
    in_ch.table_row         <= row;
    in_ch.table_col         <= col;
    in_ch.production        <= rhs;
    in_ch.production_length <= n;
    in_ch.token             <= tok;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op != OP_UNUSED) words_sent++;
  endtask

  task automatic send_token(input logic [SYM_W-1:0] tok);
    send_word(OP_TOKEN, rand_sym(), rand_sym(), rand_rhs(), LEN_W'($urandom_range(0, 15)), tok);
  endtask

  task automatic send_restart();
    send_word(OP_RESTART, rand_sym(), rand_sym(), rand_rhs(), LEN_W'($urandom_range(0, 15)),
              rand_sym());
  endtask

  task automatic put_rule(input logic [SYM_W-1:0] row, input logic [SYM_W-1:0] col,
                          input string text);
    send_word(OP_WRITE, row, col, rhs_of(text), LEN_W'(text.len()), rand_sym());
  endtask

  task automatic run_sentence(input bit broken);
    int cut;
    sentence_q.delete();
    add_expr(0);
    sentence_q = {sentence_q, $urandom_range(0, 1) ? END_MARK : NEWLINE};
    if (broken) begin
      cut = $urandom_range(0, sentence_q.size() - 1);
      sentence_q[cut] = $urandom_range(0, 1) ? any_terminal() : rand_sym();
      if ($urandom_range(0, 2) == 0) void'(sentence_q.pop_back());
    end
    send_restart();
    foreach (sentence_q[i]) send_token(sentence_q[i]);
  endtask

  task automatic run_phase(input int quota);
    int goal;
    int r;
    goal = words_sent + quota;
    while (words_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        run_sentence(1'b0);
      end else if (r < 86) begin
        run_sentence(1'b1);
      end else begin
        send_word(2'($urandom_range(0, 3)), rand_sym(), rand_sym(), rand_rhs(),
                  LEN_W'($urandom_range(0, 15)),
                  $urandom_range(0, 1) ? any_terminal() : rand_sym());
      end
    end
  endtask

  task automatic drain_block();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_start(input logic [SYM_W-1:0] v);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_wdata               = START_RESET;
    in_ch.valid             = 1'b0;
    in_ch.op                = OP_WRITE;
    in_ch.table_row         = '0;
    in_ch.table_col         = '0;
    in_ch.production        = '0;
    in_ch.production_length = '0;
    in_ch.token             = '0;
    out_ch.ready            = 1'b0;
    burst_left              = 0;
    words_sent              = 0;
    ready_hold              = 0;
    quiet_cycles            = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_token(T_ID);
    send_word(OP_UNUSED, rand_sym(), rand_sym(), rand_rhs(), '1, rand_sym());

    put_rule(NT_E, T_ID, "TR");
    put_rule(NT_E, T_OPEN, "TR");
    put_rule(NT_R, T_PLUS, "+TR");
    put_rule(NT_R, T_CLOSE, "$");
    put_rule(NT_R, END_MARK, "$");
    put_rule(NT_T, T_ID, "FY");
    put_rule(NT_T, T_OPEN, "FY");
    put_rule(NT_Y, T_PLUS, "$");
    put_rule(NT_Y, T_STAR, "*FY");
    put_rule(NT_Y, T_CLOSE, "$");
    put_rule(NT_Y, END_MARK, "$");
    put_rule(NT_F, T_ID, "i");
    put_rule(NT_F, T_OPEN, "(E)");
    put_rule(NT_S, T_ID, "E");
    put_rule(NT_S, T_OPEN, "E");
    put_rule(SYM_LOW, T_ID, "E");
    put_rule(SYM_LOW, T_OPEN, "E");
    put_rule(SYM_HIGH, T_ID, "E");
    put_rule(SYM_HIGH, T_OPEN, "E");

    send_restart();
    send_token(T_ID);
    send_token(T_PLUS);
    send_token(T_ID);
    send_token(T_STAR);
    send_token(T_OPEN);
    send_token(T_ID);
    send_token(T_CLOSE);
    send_token(NEWLINE);
    send_token(END_MARK);

    // A self-loop rule runs into the expansion limit, a growing one overflows the stack.
    put_rule(NT_S, T_LOOP, "S");
    send_restart();
    send_token(T_LOOP);
    send_token(T_ID);
    put_rule(NT_S, T_GROW, "SSSSSSSS");
    send_restart();
    send_token(T_GROW);

    // Expanding the end marker to nothing leaves the stack empty.
    send_word(OP_WRITE, NT_S, T_DROP, rand_rhs(), '0, rand_sym());
    send_word(OP_WRITE, END_MARK, T_DROP, rand_rhs(), '0, rand_sym());
    send_restart();
    send_token(T_DROP);

    send_word(OP_WRITE, NT_S, T_WIDE, rhs_of("$v$$$$$$"), '1, rand_sym());
    send_restart();
    send_token(T_WIDE);
    send_token(T_WIDE);
    send_token(END_MARK);
    send_word(OP_WRITE, NT_S, T_MASK,
              rhs_of("u$") | {{(PROD_W-2*SYM_W){1'b1}}, {(2*SYM_W){1'b0}}}, 4'd2, rand_sym());
    send_restart();
    send_token(T_MASK);
    send_token(T_MASK);
    send_token(SYM_HIGH);
    send_restart();
    send_restart();
    send_token(SYM_LOW);
    send_word(OP_WRITE, SYM_HIGH, SYM_HIGH, '1, 4'd8, SYM_LOW);
    send_word(OP_WRITE, SYM_LOW, SYM_LOW, '0, '0, SYM_HIGH);

    run_phase(PHASE_WORDS);
    set_start(NT_E);
    run_phase(PHASE_WORDS);
    set_start(SYM_LOW);
    run_phase(PHASE_WORDS);
    set_start(SYM_HIGH);
    run_phase(PHASE_WORDS);

    drain_block();
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/ll1pp_pkg.sv
src/ll1pp_if.sv
src/ll1pp_table_ram.sv
src/ll1pp_stack_ram.sv
src/ll1_predictive_parse_driver_core.sv
src/ll1pp_checker.sv
dv/ll1pp_parse_checker.sv
dv/ll1_predictive_parse_driver_core_tb.sv
